// ----- hdl/wpo_pkg.sv -----
// ----------------------------------------------------------------------------
// wpo_pkg
// Shared types and constants of the waveform peak overview block.
// ----------------------------------------------------------------------------
package wpo_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int LENGTH_WIDTH = 25;
   localparam int BUCKET_WIDTH = 16;
   localparam int CHAN_WIDTH   = 2;
   localparam int ADDR_WIDTH   = 3;

   localparam logic [ADDR_WIDTH-1:0] REG_BUCKET_LENGTH = 3'd0;
   localparam logic [ADDR_WIDTH-1:0] REG_CHANNEL_COUNT = 3'd4;

   localparam logic [SAMPLE_WIDTH-1:0] FLOAT_ZERO = 32'h0000_0000;
   localparam logic [31:0]             COUNT_MAX  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] left_bits;
      logic [31:0] right_bits;
      logic        last_frame;
   } req_type;

   typedef struct packed {
      logic [31:0] clean_left;
      logic [31:0] clean_right;
      logic        bucket_done;
      logic [15:0] bucket_number;
      logic [31:0] left_low;
      logic [31:0] left_high;
      logic [31:0] right_low;
      logic [31:0] right_high;
      logic [31:0] repair_total;
   } rsp_type;

   // True when a is strictly below b as a real number (-0 equals +0).
   function automatic logic float_less(input logic [31:0] a, input logic [31:0] b);
      logic a_neg;
      logic b_neg;
      logic a_zero;
      logic b_zero;
      a_neg  = a[31] && (a[30:0] != '0);
      b_neg  = b[31] && (b[30:0] != '0);
      a_zero = (a[30:0] == '0);
      b_zero = (b[30:0] == '0);
      if (a_neg && !b_neg) begin
         return 1'b1;
      end else if (!a_neg && b_neg) begin
         return 1'b0;
      end else if (a_neg) begin
         return a[30:0] > b[30:0];
      end else if (a_zero && b_zero) begin
         return 1'b0;
      end else begin
         return a[30:0] < b[30:0];
      end
   endfunction

endpackage

// ----- hdl/wpo_req_if.sv -----
// ----------------------------------------------------------------------------
// wpo_req_if
// Valid/ready channel carrying one audio frame per transaction.
// ----------------------------------------------------------------------------
interface wpo_req_if;
   logic            valid;
   logic            ready;
   wpo_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/wpo_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wpo_rsp_if
// Valid/ready channel carrying one overview result per transaction.
// ----------------------------------------------------------------------------
interface wpo_rsp_if;
   logic            valid;
   logic            ready;
   wpo_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/waveform_peak_overview.sv -----
// ----------------------------------------------------------------------------
// waveform_peak_overview
// Min/max overview of a mono or stereo float sample stream.
// ----------------------------------------------------------------------------
// The block takes one frame per clock cycle and gives exactly one result per
// frame, in the cycle after the frame is accepted. A frame is accepted whenever
// the output register is empty or its result is being taken in the same
// cycle, so the sustained rate is one transaction per cycle; the only limit
// is the single result register, which holds a result while the consumer
// stalls. Non-finite samples are replaced with +0.0 and counted; minimum and
// maximum per channel are tracked over buckets of bucket_length frames.
// ----------------------------------------------------------------------------
module waveform_peak_overview (
   input  logic        clock,
   input  logic        reset,
   wpo_req_if.sink     req,
   wpo_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [wpo_pkg::ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [24:0] bucket_length_ff;
   logic [1:0]  channel_count_ff;
   logic [24:0] fill_count_ff, fill_count_in;
   logic [15:0] bucket_counter_ff, bucket_counter_in;
   logic [31:0] low_ff [2];
   logic [31:0] high_ff [2];
   logic [31:0] low_in [2];
   logic [31:0] high_in [2];
   logic [31:0] repair_ff, repair_in;
   logic        rsp_valid_ff;
   wpo_pkg::rsp_type rsp_ff, rsp_in;

   logic        accept;
   logic        stereo;
   logic        bad_left, bad_right;
   logic [31:0] s0, s1;
   logic [24:0] len, fill_next;
   logic        done;
   logic [31:0] cnt1;

   assign csr_pready = 1'b1;
   // No frame is taken while reset is held.
   assign req.ready  = !reset && (!rsp_valid_ff || rsp.ready);
   assign accept     = req.valid && req.ready;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      case (csr_paddr)
         wpo_pkg::REG_BUCKET_LENGTH: csr_prdata = {7'd0, bucket_length_ff};
         wpo_pkg::REG_CHANNEL_COUNT: csr_prdata = {30'd0, channel_count_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // Per-frame datapath: repair, running min/max update and bucket closing.
   always_comb begin
      stereo    = channel_count_ff[1];
      len       = (bucket_length_ff == '0) ? 25'd1 : bucket_length_ff;
      bad_left  = (req.payload.left_bits[30:23] == 8'hFF);
      bad_right = stereo && (req.payload.right_bits[30:23] == 8'hFF);
      s0 = bad_left ? wpo_pkg::FLOAT_ZERO : req.payload.left_bits;
      s1 = !stereo ? wpo_pkg::FLOAT_ZERO
         : (bad_right ? wpo_pkg::FLOAT_ZERO : req.payload.right_bits);
      // Saturating count: each repaired sample adds one.
      cnt1 = (bad_left && repair_ff != wpo_pkg::COUNT_MAX) ? repair_ff + 32'd1 : repair_ff;
      repair_in = (bad_right && cnt1 != wpo_pkg::COUNT_MAX) ? cnt1 + 32'd1 : cnt1;

      if (fill_count_ff == '0) begin
         low_in[0] = s0; high_in[0] = s0;
         low_in[1] = s1; high_in[1] = s1;
      end else begin
         low_in[0]  = wpo_pkg::float_less(s0, low_ff[0]) ? s0 : low_ff[0];
         high_in[0] = wpo_pkg::float_less(high_ff[0], s0) ? s0 : high_ff[0];
         low_in[1]  = wpo_pkg::float_less(s1, low_ff[1]) ? s1 : low_ff[1];
         high_in[1] = wpo_pkg::float_less(high_ff[1], s1) ? s1 : high_ff[1];
      end
      if (!stereo) begin
         low_in[1]  = wpo_pkg::FLOAT_ZERO;
         high_in[1] = wpo_pkg::FLOAT_ZERO;
      end

      fill_next = fill_count_ff + 25'd1;
      done = req.payload.last_frame || (fill_next >= len) || (fill_next == '0);

      rsp_in.clean_left    = s0;
      rsp_in.clean_right   = s1;
      rsp_in.bucket_done   = done;
      rsp_in.bucket_number = done ? bucket_counter_ff : 16'd0;
      rsp_in.left_low      = done ? low_in[0] : 32'd0;
      rsp_in.left_high     = done ? high_in[0] : 32'd0;
      rsp_in.right_low     = (done && stereo) ? low_in[1] : 32'd0;
      rsp_in.right_high    = (done && stereo) ? high_in[1] : 32'd0;
      rsp_in.repair_total  = repair_in;

      fill_count_in     = done ? 25'd0 : fill_next;
      bucket_counter_in = req.payload.last_frame ? 16'd0
                        : (done ? bucket_counter_ff + 16'd1 : bucket_counter_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_length_ff  <= 25'd1;
         channel_count_ff  <= 2'd2;
         fill_count_ff     <= '0;
         bucket_counter_ff <= '0;
         low_ff[0]  <= '0; low_ff[1]  <= '0;
         high_ff[0] <= '0; high_ff[1] <= '0;
         repair_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == wpo_pkg::REG_BUCKET_LENGTH) begin
               bucket_length_ff <= csr_pwdata[24:0];
            end else if (csr_paddr == wpo_pkg::REG_CHANNEL_COUNT) begin
               channel_count_ff <= csr_pwdata[1:0];
            end
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            fill_count_ff     <= fill_count_in;
            bucket_counter_ff <= bucket_counter_in;
            if (req.payload.last_frame) begin
               low_ff[0]  <= '0; low_ff[1]  <= '0;
               high_ff[0] <= '0; high_ff[1] <= '0;
               repair_ff  <= '0;
            end else begin
               low_ff[0]  <= low_in[0];  low_ff[1]  <= low_in[1];
               high_ff[0] <= high_in[0]; high_ff[1] <= high_in[1];
               repair_ff  <= repair_in;
            end
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- verif/waveform_peak_overview_tb.sv -----
// ----------------------------------------------------------------------------
// waveform_peak_overview_tb
// Self-checking bench for the waveform peak overview block. Random and
// directed frames are pushed through the request channel while a behavioral
// predictor tracks buckets, min/max pairs and the repair count; every result
// transaction is compared field by field against the predicted queue.
// ----------------------------------------------------------------------------
module waveform_peak_overview_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [wpo_pkg::ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wpo_req_if req ();
   wpo_rsp_if rsp ();

   waveform_peak_overview dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   // Predictor copy of the registers and the bucket state.
   logic [wpo_pkg::LENGTH_WIDTH-1:0] frames_per_bucket;
   logic [wpo_pkg::CHAN_WIDTH-1:0]   channels_used;
   logic [wpo_pkg::LENGTH_WIDTH-1:0] frames_in_bucket;
   logic [wpo_pkg::BUCKET_WIDTH-1:0] open_bucket;
   logic [31:0]             low_peak[2];
   logic [31:0]             high_peak[2];
   logic [31:0]             repairs_seen;

   wpo_pkg::rsp_type expected_results[$];
   int  error_count = 0;
   int  results_seen = 0;
   int  buckets_closed = 0;
   int  frames_sent = 0;
   longint cycle_count = 0;
   bit  hold_off = 1'b0;   // long receiver stall requested by a test

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
   end

   // Ordering key: magnitude with sign applied, so -0 and +0 tie.
   function automatic longint order_of(input logic [31:0] bits);
      longint mag;
      mag = longint'(bits[30:0]);
      return bits[31] ? -mag : mag;
   endfunction

   function automatic logic [31:0] scrub(input logic [31:0] bits);
      if (bits[30:23] == 8'hFF) begin
         if (repairs_seen != wpo_pkg::COUNT_MAX) repairs_seen++;
         return wpo_pkg::FLOAT_ZERO;
      end
      return bits;
   endfunction

   function automatic void clear_bucket_state();
      frames_in_bucket = '0;
      open_bucket = '0;
      low_peak = '{0, 0};
      high_peak = '{0, 0};
      repairs_seen = '0;
   endfunction

   // Works out the single result caused by one frame and queues it.
   function automatic void predict_overview(input wpo_pkg::req_type f);
      wpo_pkg::rsp_type r;
      logic stereo;
      logic [wpo_pkg::LENGTH_WIDTH-1:0] len;
      logic [31:0] s[2];
      logic done;
      stereo = (channels_used >= 2);
      len = (frames_per_bucket == 0) ? wpo_pkg::LENGTH_WIDTH'(1) : frames_per_bucket;
      s[0] = scrub(f.left_bits);
      s[1] = stereo ? scrub(f.right_bits) : wpo_pkg::FLOAT_ZERO;
      for (int ch = 0; ch < (stereo ? 2 : 1); ch++) begin
         if (frames_in_bucket == 0) begin
            low_peak[ch] = s[ch];
            high_peak[ch] = s[ch];
         end else begin
            if (order_of(s[ch]) < order_of(low_peak[ch])) low_peak[ch] = s[ch];
            if (order_of(high_peak[ch]) < order_of(s[ch])) high_peak[ch] = s[ch];
         end
      end
      if (!stereo) begin
         low_peak[1] = '0;
         high_peak[1] = '0;
      end
      frames_in_bucket = frames_in_bucket + wpo_pkg::LENGTH_WIDTH'(1);
      done = f.last_frame || frames_in_bucket >= len || frames_in_bucket == 0;
      r = '0;
      r.clean_left = s[0];
      r.clean_right = s[1];
      r.bucket_done = done;
      if (done) begin
         r.bucket_number = open_bucket;
         r.left_low = low_peak[0];
         r.left_high = high_peak[0];
         if (stereo) begin
            r.right_low = low_peak[1];
            r.right_high = high_peak[1];
         end
      end
      r.repair_total = repairs_seen;
      expected_results.push_back(r);
      if (f.last_frame) clear_bucket_state();
      else if (done) begin
         frames_in_bucket = '0;
         open_bucket = open_bucket + wpo_pkg::BUCKET_WIDTH'(1);
      end
   endfunction

   // Random idle cycles: mostly short, occasionally long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Valid stays high after a handshake so that frames can follow back to
   // back; it drops at the start of a gap or when the bench goes idle.
   task automatic send_frame(input wpo_pkg::req_type f);
      int gap;
      gap = pick_gap();
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= f;
      do @(posedge clock); while (!req.ready);
      predict_overview(f);
      frames_sent++;
   endtask

   task automatic write_register(input logic [wpo_pkg::ADDR_WIDTH-1:0] addr,
                                 input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == wpo_pkg::REG_BUCKET_LENGTH)
         frames_per_bucket = value[wpo_pkg::LENGTH_WIDTH-1:0];
      else if (addr == wpo_pkg::REG_CHANNEL_COUNT)
         channels_used = value[wpo_pkg::CHAN_WIDTH-1:0];
      @(posedge clock);
   endtask

   // Registers change only when no result is outstanding.
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] length, input logic [31:0] chans);
      wait_idle();
      write_register(wpo_pkg::REG_BUCKET_LENGTH, length);
      write_register(wpo_pkg::REG_CHANNEL_COUNT, chans);
   endtask

   // Random sample: special encodings are favored to hit repair and zeros.
   function automatic logic [31:0] random_sample();
      case ($urandom_range(9))
         0: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
         1: return {1'($urandom_range(1)), 31'h0};
         2: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
         3: return $urandom;
         default: return {1'($urandom_range(1)), 8'($urandom_range(140, 110)),
                          23'($urandom)};
      endcase
   endfunction

   function automatic wpo_pkg::req_type make_frame(input logic last);
      wpo_pkg::req_type f;
      f.left_bits = random_sample();
      f.right_bits = random_sample();
      f.last_frame = last;
      return f;
   endfunction

   // Directed: extremes of each field, signed zero ties, non-finite repair,
   // zero bucket length, mono with junk on the right side.
   task automatic test_directed();
      wpo_pkg::req_type f;
      configure(3, 2);
      f = '{32'h8000_0000, 32'h0000_0000, 1'b0}; send_frame(f);
      f = '{32'h0000_0000, 32'h8000_0000, 1'b0}; send_frame(f);
      f = '{32'h7F80_0000, 32'hFF80_0001, 1'b0}; send_frame(f);
      f = '{32'hFFFF_FFFF, 32'h7F7F_FFFF, 1'b0}; send_frame(f);
      f = '{32'hFF7F_FFFF, 32'h0000_0001, 1'b0}; send_frame(f);
      f = '{32'h3F80_0000, 32'hBF80_0000, 1'b1}; send_frame(f);
      configure(0, 1);
      f = '{32'h4000_0000, 32'h7FC0_0000, 1'b0}; send_frame(f);
      f = '{32'hC000_0000, 32'hFFFF_FFFF, 1'b0}; send_frame(f);
      f = '{32'h0000_0000, 32'h0000_0000, 1'b1}; send_frame(f);
      configure(4, 0);
      f = '{32'h7F80_0000, 32'h1234_5678, 1'b0}; send_frame(f);
      f = '{32'h8000_0001, 32'h0, 1'b0}; send_frame(f);
      f = '{32'h0000_0001, 32'h0, 1'b1}; send_frame(f);
      configure(2, 3);
      for (int i = 0; i < 6; i++) send_frame(make_frame(i == 5));
   endtask

   // Streams of random frames with a last marker closing each stream.
   task automatic test_streams(input logic [31:0] length, input logic [31:0] chans,
                               input int count);
      configure(length, chans);
      for (int i = 0; i < count; i++)
         send_frame(make_frame(($urandom_range(19) == 0) || i == count - 1));
   endtask

   // The receiver stalls for a long stretch while frames keep coming.
   task automatic test_backpressure();
      configure(5, 2);
      hold_off = 1'b1;
      for (int i = 0; i < 20; i++) send_frame(make_frame(i == 19));
      hold_off = 1'b0;
   endtask

   // Very large bucket lengths up to the largest: a bucket closes only at the last frame.
   task automatic test_long_bucket();
      configure(32'h0100_0000, 2);
      for (int i = 0; i < 30; i++) send_frame(make_frame(i == 29));
      configure(32'h01FF_FFFF, 1);
      for (int i = 0; i < 10; i++) send_frame(make_frame(i == 9));
   endtask

   // Receiver: random stalls of random length, plus a counted hold-off
   // while requested.
   initial begin
      int stall_left;
      int held;
      held = 0;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && held < 60) begin
            held++;
            rsp.ready <= 1'b0;
         end else begin
            if (!hold_off) held = 0;
            if (stall_left == 0 && $urandom_range(4) == 0) stall_left = pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               rsp.ready <= 1'b0;
            end else begin
               rsp.ready <= 1'b1;
            end
         end
      end
   end

   // Result checker: compares each accepted transaction with the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      wpo_pkg::rsp_type got;
      wpo_pkg::rsp_type want;
      cycle_count++;
      if (!reset && rsp.valid && rsp.ready) begin
         got = rsp.payload;
         results_seen++;
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t unexpected result %h", $time, got);
         end else begin
            want = expected_results.pop_front();
            if (want.bucket_done) buckets_closed++;
            if (got.clean_left !== want.clean_left ||
                got.clean_right !== want.clean_right ||
                got.bucket_done !== want.bucket_done ||
                got.bucket_number !== want.bucket_number ||
                got.left_low !== want.left_low ||
                got.left_high !== want.left_high ||
                got.right_low !== want.right_low ||
                got.right_high !== want.right_high ||
                got.repair_total !== want.repair_total) begin
               error_count++;
               $display("%0t mismatch: expected %h actual %h", $time, want, got);
            end
         end
      end
   end

   // Cycle limit guard.
   always @(posedge clock) begin
      if (cycle_count > 200000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      frames_per_bucket = 1;
      channels_used = 2;
      clear_bucket_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_streams(1, 2, 80);
      test_streams(7, 1, 120);
      test_streams(16, 2, 150);
      test_long_bucket();
      test_streams(3, 2, 100);
      wait_idle();
      repeat (10) @(posedge clock);
      $display("Covered %0d frames, %0d results, %0d closed buckets.",
               frames_sent, results_seen, buckets_closed);
      $display("Register settings: bucket lengths 0 to max, mono and stereo.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- waveform_peak_overview.f -----
hdl/wpo_pkg.sv
hdl/wpo_req_if.sv
hdl/wpo_rsp_if.sv
hdl/waveform_peak_overview.sv
verif/waveform_peak_overview_tb.sv
